@@ hdl/dt2fx_pkg.sv @@
package dt2fx_pkg;

	localparam int FRAC_BITS    = 32;
	localparam int INT_BITS     = 31;
	localparam int WEIGHT_BITS  = 60;
	localparam int VALUE_BITS   = 64;
	localparam int STATUS_BITS  = 2;
	localparam int CHAR_BITS    = 8;
	localparam int DIGIT_BITS   = 4;
	localparam int INT_CALC_BITS = INT_BITS + DIGIT_BITS;
	localparam int PROD_BITS    = WEIGHT_BITS + DIGIT_BITS;

	// one weight per fraction digit position, the last one is zero
	localparam int WEIGHT_STEPS = 19;
	localparam int WIDX_BITS    = $clog2(WEIGHT_STEPS);

	localparam int QUEUE_DEPTH  = 4;
	localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'd48;
	localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'd57;
	localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_BITS-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_BITS-1:0] CH_DOT   = ".";
	localparam logic [CHAR_BITS-1:0] CH_PLUS  = "+";
	localparam logic [CHAR_BITS-1:0] CH_MINUS = "-";

	localparam logic [INT_BITS-1:0] INT_MAX = '1;
	localparam logic [INT_CALC_BITS-1:0] TEN = INT_CALC_BITS'(10);

	localparam logic [VALUE_BITS-1:0] SAT_POS =
		VALUE_BITS'({(INT_BITS + FRAC_BITS){1'b1}});
	localparam logic [VALUE_BITS-1:0] SAT_NEG = ~SAT_POS;

	typedef enum logic [1:0] {
		PH_SPACE,
		PH_SIGN,
		PH_BODY
	} phase_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_SKIP,
		OP_INT,
		OP_FRAC
	} op_kind_t;

	typedef struct packed {
		op_kind_t                kind;
		logic [DIGIT_BITS-1:0]   digit;
		logic [WIDX_BITS-1:0]    widx;
		logic                    last;
		logic                    neg;
		logic                    bad;
	} op_t;

	typedef logic [WEIGHT_BITS-1:0] weight_tab_t [WEIGHT_STEPS];

	function automatic weight_tab_t build_weights();
		logic [WEIGHT_BITS:0] w;
		weight_tab_t          t;
		w = {1'b1, {WEIGHT_BITS{1'b0}}};
		for (int i = 0; i < WEIGHT_STEPS; i++) begin
			w    = w / 10;
			t[i] = w[WEIGHT_BITS-1:0];
		end
		return t;
	endfunction

	localparam weight_tab_t WEIGHT_TAB = build_weights();

endpackage

@@ hdl/dt2fx_char_if.sv @@
interface dt2fx_char_if;
	logic                               valid;
	logic                               ready;
	logic [dt2fx_pkg::CHAR_BITS-1:0]    char_code;
	logic                               is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink (input valid, input char_code, input is_last, output ready);
endinterface

@@ hdl/dt2fx_result_if.sv @@
interface dt2fx_result_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dt2fx_pkg::VALUE_BITS-1:0] value;
	logic [dt2fx_pkg::STATUS_BITS-1:0]      status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

@@ hdl/dt2fx_front.sv @@
module dt2fx_front (
	input  logic                 clk,
	input  logic                 arst_n,
	dt2fx_char_if.sink           chars,
	output dt2fx_pkg::op_t       op,
	output logic                 op_valid,
	input  logic                 op_ready
);

	dt2fx_pkg::phase_t                    phase_q, phase_d;
	logic                                 neg_q, neg_d;
	logic                                 dot_q, dot_d;
	logic                                 bad_q, bad_d;
	logic [dt2fx_pkg::WIDX_BITS-1:0]      fcnt_q, fcnt_d;

	logic push;
	logic is_space, is_sign, is_digit, is_dot;
	logic skip_space, take_sign, take_body;

	assign chars.ready = op_ready;
	assign op_valid    = chars.valid;
	assign push        = chars.valid && op_ready;

	assign is_space = (chars.char_code >= dt2fx_pkg::CH_TAB && chars.char_code <= dt2fx_pkg::CH_CR)
		|| chars.char_code == dt2fx_pkg::CH_SPACE;
	assign is_sign  = chars.char_code == dt2fx_pkg::CH_PLUS
		|| chars.char_code == dt2fx_pkg::CH_MINUS;
	assign is_digit = chars.char_code >= dt2fx_pkg::CH_ZERO
		&& chars.char_code <= dt2fx_pkg::CH_NINE;
	assign is_dot   = chars.char_code == dt2fx_pkg::CH_DOT;

	assign skip_space = phase_q == dt2fx_pkg::PH_SPACE && is_space;
	assign take_sign  = !skip_space && phase_q != dt2fx_pkg::PH_BODY && is_sign;
	assign take_body  = !bad_q && !skip_space && !take_sign;

	// next state
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		dot_d   = dot_q;
		bad_d   = bad_q;
		fcnt_d  = fcnt_q;
		if (!bad_q && take_sign) begin
			phase_d = dt2fx_pkg::PH_SIGN;
			if (chars.char_code == dt2fx_pkg::CH_MINUS) begin
				neg_d = !neg_q;
			end
		end else if (take_body) begin
			phase_d = dt2fx_pkg::PH_BODY;
			priority if (is_dot) begin
				if (dot_q) begin
					bad_d = 1'b1;
				end else begin
					dot_d = 1'b1;
				end
			end else if (is_digit) begin
				if (dot_q && fcnt_q != dt2fx_pkg::WIDX_BITS'(dt2fx_pkg::WEIGHT_STEPS - 1)) begin
					fcnt_d = fcnt_q + 1'b1;
				end
			end else begin
				bad_d = 1'b1;
			end
		end
	end

	// queue entry
	always_comb begin
		op.kind  = dt2fx_pkg::OP_SKIP;
		op.digit = dt2fx_pkg::DIGIT_BITS'(chars.char_code - dt2fx_pkg::CH_ZERO);
		op.widx  = fcnt_q;
		op.last  = chars.is_last;
		op.neg   = neg_d;
		op.bad   = bad_d;
		if (take_body && is_digit) begin
			op.kind = dot_q ? dt2fx_pkg::OP_FRAC : dt2fx_pkg::OP_INT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dt2fx_pkg::PH_SPACE;
			neg_q   <= 1'b0;
			dot_q   <= 1'b0;
			bad_q   <= 1'b0;
			fcnt_q  <= '0;
		end else if (push) begin
			if (chars.is_last) begin
				phase_q <= dt2fx_pkg::PH_SPACE;
				neg_q   <= 1'b0;
				dot_q   <= 1'b0;
				bad_q   <= 1'b0;
				fcnt_q  <= '0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				dot_q   <= dot_d;
				bad_q   <= bad_d;
				fcnt_q  <= fcnt_d;
			end
		end
	end

	a_text_restart: assert property (@(posedge clk) disable iff (!arst_n)
		push && chars.is_last |=> phase_q == dt2fx_pkg::PH_SPACE && !bad_q && !dot_q && !neg_q)
		else $error("front state not cleared after last item");

	a_frac_needs_dot: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q != '0 |-> dot_q)
		else $error("fraction digits counted without a dot");

	a_sign_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == dt2fx_pkg::PH_SPACE |-> !neg_q)
		else $error("negative set while still skipping whitespace");

endmodule

@@ hdl/dt2fx_fifo.sv @@
module dt2fx_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dt2fx_pkg::op_t       wr_data,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	output dt2fx_pkg::op_t       rd_data,
	output logic                 rd_valid,
	input  logic                 rd_ready
);

	dt2fx_pkg::op_t                   mem_q [dt2fx_pkg::QUEUE_DEPTH];
	logic [dt2fx_pkg::PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [dt2fx_pkg::CNT_BITS-1:0]   count_q;
	logic push, pop;

	assign wr_ready = count_q != dt2fx_pkg::CNT_BITS'(dt2fx_pkg::QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == dt2fx_pkg::PTR_BITS'(dt2fx_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == dt2fx_pkg::PTR_BITS'(dt2fx_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/dt2fx_back.sv @@
module dt2fx_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dt2fx_pkg::op_t       op,
	input  logic                 op_valid,
	output logic                 op_ready,
	dt2fx_result_if.source       result
);

	logic en, pop;

	// integer accumulator, updated as entries leave the queue
	logic [dt2fx_pkg::INT_BITS-1:0]      int_acc_q;
	logic                                ovf_q;
	logic [dt2fx_pkg::INT_CALC_BITS-1:0] int_calc;
	logic                                int_over;
	logic [dt2fx_pkg::INT_BITS-1:0]      int_upd;
	logic                                ovf_upd;
	logic [dt2fx_pkg::PROD_BITS-1:0]     prod_wide;

	logic                                vld_s1, last_s1, neg_s1, bad_s1, ovf_s1;
	logic [dt2fx_pkg::INT_BITS-1:0]      int_s1;
	logic [dt2fx_pkg::WEIGHT_BITS-1:0]   prod_s1;

	logic [dt2fx_pkg::WEIGHT_BITS-1:0]   frac_acc_q;
	logic [dt2fx_pkg::WEIGHT_BITS-1:0]   frac_sum;

	logic                                vld_s2, neg_s2, bad_s2, ovf_s2;
	logic [dt2fx_pkg::INT_BITS-1:0]      int_s2;
	logic [dt2fx_pkg::FRAC_BITS-1:0]     frac_s2;

	logic                                out_vld_q;
	logic [dt2fx_pkg::VALUE_BITS-1:0]    value_q;
	dt2fx_pkg::status_t                  status_q;
	logic [dt2fx_pkg::VALUE_BITS-1:0]    mag;

	assign en       = !out_vld_q || result.ready;
	assign op_ready = en;
	assign pop      = op_valid && en;

	assign int_calc  = dt2fx_pkg::INT_CALC_BITS'(int_acc_q) * dt2fx_pkg::TEN
		+ dt2fx_pkg::INT_CALC_BITS'(op.digit);
	assign int_over  = int_calc > dt2fx_pkg::INT_CALC_BITS'(dt2fx_pkg::INT_MAX);
	assign prod_wide = dt2fx_pkg::PROD_BITS'(dt2fx_pkg::WEIGHT_TAB[op.widx])
		* dt2fx_pkg::PROD_BITS'(op.digit);

	always_comb begin
		int_upd = int_acc_q;
		ovf_upd = ovf_q;
		if (op.kind == dt2fx_pkg::OP_INT) begin
			int_upd = int_over ? dt2fx_pkg::INT_MAX : int_calc[dt2fx_pkg::INT_BITS-1:0];
			ovf_upd = ovf_q || int_over;
		end
	end

	assign frac_sum = frac_acc_q + prod_s1;
	assign mag      = dt2fx_pkg::VALUE_BITS'({int_s2, frac_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_acc_q  <= '0;
			ovf_q      <= 1'b0;
			frac_acc_q <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1    <= op_valid;
			vld_s2    <= vld_s1 && last_s1;
			out_vld_q <= vld_s2;
			if (op_valid) begin
				int_acc_q <= op.last ? '0 : int_upd;
				ovf_q     <= op.last ? 1'b0 : ovf_upd;
			end
			if (vld_s1) begin
				frac_acc_q <= last_s1 ? '0 : frac_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			last_s1 <= op.last;
			neg_s1  <= op.neg;
			bad_s1  <= op.bad;
			ovf_s1  <= ovf_upd;
			int_s1  <= int_upd;
			prod_s1 <= (op.kind == dt2fx_pkg::OP_FRAC)
				? prod_wide[dt2fx_pkg::WEIGHT_BITS-1:0] : '0;
		end
		if (en) begin
			neg_s2  <= neg_s1;
			bad_s2  <= bad_s1;
			ovf_s2  <= ovf_s1;
			int_s2  <= int_s1;
			frac_s2 <= frac_sum[dt2fx_pkg::WEIGHT_BITS-1 -: dt2fx_pkg::FRAC_BITS];
			priority if (bad_s2) begin
				value_q  <= '0;
				status_q <= dt2fx_pkg::ST_INVALID;
			end else if (ovf_s2) begin
				value_q  <= neg_s2 ? dt2fx_pkg::SAT_NEG : dt2fx_pkg::SAT_POS;
				status_q <= dt2fx_pkg::ST_OVERFLOW;
			end else begin
				value_q  <= neg_s2 ? (~mag + 1'b1) : mag;
				status_q <= dt2fx_pkg::ST_OK;
			end
		end
	end

	assign result.valid  = out_vld_q;
	assign result.value  = $signed(value_q);
	assign result.status = status_q;

	a_ovf_pins_int: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> int_acc_q == dt2fx_pkg::INT_MAX)
		else $error("overflow flagged but integer part not saturated");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && status_q == dt2fx_pkg::ST_OVERFLOW
		|-> value_q == dt2fx_pkg::SAT_POS || value_q == dt2fx_pkg::SAT_NEG)
		else $error("overflow status with unsaturated value");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && status_q == dt2fx_pkg::ST_INVALID |-> value_q == '0)
		else $error("invalid status with nonzero value");

endmodule

@@ hdl/decimal_text_to_fixed_point.sv @@
// decimal text to signed Q31.32 fixed point
// chars: one ASCII character per item (char_code), is_last marks the final one
// result: one item per text, sent for the item with is_last set; value is the
//   signed fixed-point number, status is ok, invalid (bad character or second
//   dot, value zero) or overflow (value saturated to the extreme of its sign)
// leading whitespace is skipped, any run of signs follows, then digits and at
//   most one dot; fraction digits beyond the resolution of the weight table add
//   nothing
// throughput: one character per cycle; the front classifies each character in
//   the cycle it is taken and pushes it into a four-entry queue, the back
//   accumulates one queue entry per cycle
// path: after the last character is taken the result goes through the stages
//   queue read, integer/product stage, fraction add stage, output register
// reset: arst_n clears the parser state, the accumulators and the queue; the
//   next character starts a new text
// stall: while a result waits for result.ready the back holds, the queue keeps
//   taking characters until its four entries are full, then chars.ready drops
module decimal_text_to_fixed_point (
	input  logic            clk,
	input  logic            arst_n,
	dt2fx_char_if.sink      chars,
	dt2fx_result_if.source  result
);

	dt2fx_pkg::op_t front_op, back_op;
	logic           front_valid, front_ready;
	logic           back_valid, back_ready;

	dt2fx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.op       (front_op),
		.op_valid (front_valid),
		.op_ready (front_ready)
	);

	dt2fx_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (front_op),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_data  (back_op),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	dt2fx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (back_op),
		.op_valid (back_valid),
		.op_ready (back_ready),
		.result   (result)
	);

endmodule
